FILE: hdl/assert_macros.svh
// assertion macros for the nlms adaptive fir
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NLMS_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("nlms assertion failed");
`define NLMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlms implication failed");
`else
`define NLMS_ASSERT(lbl, clk, rst_n, expr)
`define NLMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/nlms_pkg.sv
// shared widths and constants of the nlms adaptive fir
`timescale 1ns / 1ps
`default_nettype none
package nlms_pkg;
    localparam int TAP_COUNT_DEF = 16;
    localparam int X_W           = 16;
    localparam int W_W           = 32;
    localparam int O_W           = 18;
    localparam int F_W           = 48;
    localparam int M_W           = 33;
    localparam int IDX_IN_W      = 4;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 72;
    localparam logic [15:0] STEP_RESET = 16'd16384;
    localparam logic OP_ADAPT = 1'b0;
    localparam logic OP_READ  = 1'b1;
    localparam logic [F_W-1:0] F_CAP = 48'h8000_0000_0000;
endpackage
`default_nettype wire

FILE: hdl/nlms_div.sv
// restoring divider for the normalised step factor, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module nlms_div #(
    parameter int DEN_W = 35
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [nlms_pkg::M_W-1:0]       i_num,
    input  wire logic [DEN_W-1:0]               i_den,
    output logic                                o_done,
    output logic [nlms_pkg::F_W-1:0]            o_quot
);
    localparam int F_W = nlms_pkg::F_W;
    localparam int C_W = $clog2(F_W + 1);

    logic             r_busy;
    logic [C_W-1:0]   r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [F_W-1:0]   r_low;
    logic [F_W-1:0]   r_q;
    logic             r_done;
    logic [F_W-1:0]   r_quot;

    logic [DEN_W:0]   t;
    logic             ge;
    logic [DEN_W:0]   t_sub;
    logic [DEN_W-1:0] n_rem;
    logic [F_W-1:0]   n_q;
    logic [DEN_W-1:0] hi;

    always_comb begin
        t     = {r_rem, r_low[F_W-1]};
        ge    = t >= {1'b0, r_den};
        t_sub = t - {1'b0, r_den};
        n_rem = ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
        n_q   = {r_q[F_W-2:0], ge};
        hi    = DEN_W'(i_num[nlms_pkg::M_W-1:18]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_q   <= '0;
                r_low <= {i_num[17:0], 30'b0};
                r_rem <= hi;
                if (hi >= i_den) begin
                    r_done <= 1'b1;
                    r_quot <= nlms_pkg::F_CAP;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= C_W'(F_W);
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_low <= {r_low[F_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= (n_q > nlms_pkg::F_CAP) ? nlms_pkg::F_CAP : n_q;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

FILE: hdl/nlms_adaptive_fir.sv
// normalised lms adaptive fir top level: control, tap and weight memories, datapath
// An adapt item forms the output and energy from its accept, one tap a cycle through the delay
// and weight memory read ports, then the output and error, then the divider (start plus one
// quotient bit a cycle, start alone when the factor is clamped), then the weight update and
// the load of the result; a zero-energy item skips division and update. A read item reads
// one weight and loads it as the result, an index beyond the taps reading as zero.
// One item is in work at a time;
// a finished result waits in the output register while the next item is accepted.
// The step size register may be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module nlms_adaptive_fir #(
    parameter int TAP_COUNT = nlms_pkg::TAP_COUNT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [15:0]                         i_cfg_wr_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // x_sample, desired, weight_index, zero pad
    input  wire logic [nlms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // filter_out, error, weight_value, zero pad
    output logic [nlms_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // energy_zero
    output logic [0:0]                               m_axis_tuser
);
    localparam int IDX_W = $clog2(TAP_COUNT);
    localparam int CNT_W = IDX_W + 1;
    localparam int ACC_W = 48 + IDX_W;
    localparam int EN_W  = 31 + IDX_W;
    localparam int YF_W  = ACC_W - 30;
    localparam int X_W   = nlms_pkg::X_W;
    localparam int W_W   = nlms_pkg::W_W;
    localparam int O_W   = nlms_pkg::O_W;
    localparam int F_W   = nlms_pkg::F_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDW  = 4'd1;
    localparam logic [3:0] ST_SUM  = 4'd2;
    localparam logic [3:0] ST_YC   = 4'd3;
    localparam logic [3:0] ST_EC   = 4'd4;
    localparam logic [3:0] ST_DIVS = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam logic signed [YF_W-1:0] Y_MAX = YF_W'(131071);
    localparam logic signed [YF_W-1:0] Y_MIN = YF_W'(-131072);
    localparam logic signed [O_W:0]    E_MAX = (O_W+1)'(131071);
    localparam logic signed [O_W:0]    E_MIN = (O_W+1)'(-131072);
    localparam logic signed [W_W+18:0] W_MAX = (W_W+19)'(64'sd2147483647);
    localparam logic signed [W_W+18:0] W_MIN = (W_W+19)'(-64'sd2147483648);

    logic [3:0]            r_state;
    logic [15:0]           r_step;
    logic [IDX_W-1:0]      r_wp;
    logic [CNT_W-1:0]      r_cnt;
    logic [TAP_COUNT-1:0]  r_dv;
    logic [TAP_COUNT-1:0]  r_wv;
    logic [X_W-1:0]        m_dly [TAP_COUNT];
    logic [W_W-1:0]        m_wgt [TAP_COUNT];
    logic [X_W-1:0]        r_x_rd;
    logic [W_W-1:0]        r_w_rd;
    logic                  r_xv;
    logic                  r_wvv;
    logic                  r_vld1;
    logic [IDX_W-1:0]      r_idx1;
    logic signed [ACC_W-1:0] r_acc;
    logic [EN_W-1:0]       r_en;
    logic signed [X_W-1:0] r_d;
    logic signed [O_W-1:0] r_y;
    logic signed [O_W-1:0] r_e;
    logic                  r_ez;
    logic [F_W-1:0]        r_f;
    logic [63:0]           r_prod;
    logic signed [W_W-1:0] r_wd2;
    logic                  r_neg2;
    logic [IDX_W-1:0]      r_idx2;
    logic                  r_vld2;
    logic [W_W-1:0]        r_res_w;
    logic                  r_oob;
    logic                  r_m_valid;
    logic [nlms_pkg::OUT_TDATA_W-1:0] r_m_data;
    logic                  r_m_user;

    logic                  acc_in;
    logic                  op;
    logic signed [X_W-1:0] in_x;
    logic [IDX_W-1:0]      wp_nx;
    logic                  issue;
    logic [CNT_W-1:0]      diff;
    logic [IDX_W-1:0]      dly_ra;
    logic [IDX_W-1:0]      wgt_ra;
    logic signed [X_W-1:0] x_now;
    logic signed [W_W-1:0] w_now;
    logic signed [47:0]    prod_xw;
    logic signed [31:0]    prod_xx;
    logic signed [ACC_W-1:0] yr;
    logic signed [YF_W-1:0]  y_full;
    logic signed [O_W-1:0]   y_sat;
    logic signed [O_W:0]     e_full;
    logic signed [O_W-1:0]   e_sat;
    logic [O_W-1:0]        e_mag;
    logic [nlms_pkg::M_W-1:0] m_num;
    logic [X_W-1:0]        xm;
    logic [64:0]           rnd;
    logic [48:0]           dm;
    logic signed [W_W+18:0] w_sum;
    logic signed [W_W-1:0] w_new;
    logic                  div_start;
    logic                  div_done;
    logic [F_W-1:0]        div_q;
    logic                  out_load;

    always_comb begin
        op      = s_axis_tuser[0];
        in_x    = s_axis_tdata[15:0];
        acc_in  = s_axis_tvalid && s_axis_tready;
        wp_nx   = (r_wp == IDX_W'(TAP_COUNT - 1)) ? '0 : r_wp + 1'b1;
        issue   = (r_state == ST_SUM || r_state == ST_UPD) && (r_cnt < CNT_W'(TAP_COUNT));
        diff    = CNT_W'(r_wp) + CNT_W'(TAP_COUNT) - r_cnt;
        if (diff >= CNT_W'(TAP_COUNT)) begin
            diff = diff - CNT_W'(TAP_COUNT);
        end
        dly_ra  = diff[IDX_W-1:0];
        wgt_ra  = (r_state == ST_IDLE) ? IDX_W'(s_axis_tdata[35:32]) : r_cnt[IDX_W-1:0];
        x_now   = r_xv ? signed'(r_x_rd) : '0;
        w_now   = r_wvv ? signed'(r_w_rd) : '0;
        prod_xw = x_now * w_now;
        prod_xx = x_now * x_now;
        yr      = r_acc + ACC_W'(64'sd536870912);
        y_full  = signed'(yr[ACC_W-1:30]);
        if (y_full > Y_MAX) begin
            y_sat = O_W'(Y_MAX);
        end else if (y_full < Y_MIN) begin
            y_sat = O_W'(Y_MIN);
        end else begin
            y_sat = O_W'(y_full);
        end
        e_full  = (O_W+1)'(r_d) - (O_W+1)'(r_y);
        if (e_full > E_MAX) begin
            e_sat = O_W'(E_MAX);
        end else if (e_full < E_MIN) begin
            e_sat = O_W'(E_MIN);
        end else begin
            e_sat = O_W'(e_full);
        end
        e_mag   = r_e[O_W-1] ? O_W'(-r_e) : O_W'(r_e);
        m_num   = nlms_pkg::M_W'(r_step * e_mag);
        xm      = x_now[X_W-1] ? X_W'(-x_now) : X_W'(x_now);
        rnd     = {1'b0, r_prod} + 65'(16384);
        dm      = rnd[63:15];
        w_sum   = r_neg2 ? (W_W+19)'(r_wd2) - signed'({2'b0, dm})
                         : (W_W+19)'(r_wd2) + signed'({2'b0, dm});
        if (w_sum > W_MAX) begin
            w_new = W_W'(W_MAX);
        end else if (w_sum < W_MIN) begin
            w_new = W_W'(W_MIN);
        end else begin
            w_new = W_W'(w_sum);
        end
        div_start = (r_state == ST_DIVS);
        out_load  = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);
    end

    // tap delay line memory
    always_ff @(posedge i_clk) begin
        if (acc_in && op == nlms_pkg::OP_ADAPT) begin
            m_dly[wp_nx] <= in_x;
        end
        r_x_rd <= m_dly[dly_ra];
    end

    // weight memory
    always_ff @(posedge i_clk) begin
        if (r_vld2) begin
            m_wgt[r_idx2] <= w_new;
        end
        r_w_rd <= m_wgt[wgt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= nlms_pkg::STEP_RESET;
            r_wp      <= '0;
            r_cnt     <= '0;
            r_dv      <= '0;
            r_wv      <= '0;
            r_xv      <= 1'b0;
            r_wvv     <= 1'b0;
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            r_xv   <= r_dv[dly_ra];
            r_wvv  <= r_wv[wgt_ra];
            r_vld1 <= issue;
            r_idx1 <= r_cnt[IDX_W-1:0];
            r_vld2 <= r_vld1 && (r_state == ST_UPD);
            r_idx2 <= r_idx1;
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_vld2) begin
                r_wv[r_idx2] <= 1'b1;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_cnt <= '0;
                        if (op == nlms_pkg::OP_READ) begin
                            r_oob   <= 32'(s_axis_tdata[35:32]) >= TAP_COUNT;
                            r_state <= ST_RDW;
                        end else begin
                            r_wp        <= wp_nx;
                            r_dv[wp_nx] <= 1'b1;
                            r_d         <= signed'(s_axis_tdata[31:16]);
                            r_acc       <= '0;
                            r_en        <= '0;
                            r_res_w     <= '0;
                            r_state     <= ST_SUM;
                        end
                    end
                end
                ST_RDW: begin
                    r_res_w <= r_oob ? '0 : w_now;
                    r_y     <= '0;
                    r_e     <= '0;
                    r_ez    <= 1'b0;
                    r_state <= ST_OUT;
                end
                ST_SUM: begin
                    if (r_vld1) begin
                        r_acc <= r_acc + ACC_W'(prod_xw);
                        r_en  <= r_en + EN_W'(unsigned'(prod_xx[30:0]));
                    end else if (!issue) begin
                        r_state <= ST_YC;
                    end
                end
                ST_YC: begin
                    r_y     <= y_sat;
                    r_state <= ST_EC;
                end
                ST_EC: begin
                    r_e  <= e_sat;
                    r_ez <= (r_en == '0);
                    r_state <= (r_en == '0) ? ST_OUT : ST_DIVS;
                end
                ST_DIVS: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_f     <= div_q;
                        r_cnt   <= '0;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_vld1) begin
                        r_prod <= r_f * xm;
                        r_wd2  <= w_now;
                        r_neg2 <= r_e[O_W-1] ^ x_now[X_W-1];
                    end
                    if (!issue && !r_vld1 && !r_vld2) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_m_data <= {4'b0, r_res_w, r_e, r_y};
                        r_m_user <= r_ez;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    nlms_div #(
        .DEN_W (EN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (m_num),
        .i_den   (r_en),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`include "assert_macros.svh"
    `NLMS_ASSERT_IMP(a_wr_in_upd, i_clk, i_rst_n, r_vld2, r_state == ST_UPD)
    `NLMS_ASSERT_IMP(a_div_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV)
    `NLMS_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_W'(TAP_COUNT))
    `NLMS_ASSERT_IMP(a_zero_skip, i_clk, i_rst_n, r_state == ST_UPD, !r_ez)
endmodule
`default_nettype wire
